/* sv/nau_pkg.sv */
// ============================================================================
// nau_pkg
// Shared types, constants and the sigmoid lookup table of the neuron
// activation unit.
// ============================================================================
package nau_pkg;

    localparam int SIGMOID_ENTRIES = 256;
    localparam int SUM_WIDTH       = 24;

    localparam int SIG_IDX_W  = $clog2(SIGMOID_ENTRIES);
    localparam int SIG_PROD_W = 12 + $clog2(SIGMOID_ENTRIES + 1);

    localparam int DATA_W  = 16;
    localparam int CFG_W   = 16;
    localparam int STEEP_W = 25;

    localparam longint unsigned ONE_Q32    = 64'd4294967296;
    localparam longint unsigned EXP_M1_Q32 = 64'd1580030169;
    localparam longint unsigned HALF_Q32   = 64'd2147483648;

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        MODE_SIGMOID = 3'd0,
        MODE_STEEP   = 3'd1,
        MODE_RELU    = 3'd2,
        MODE_STEP    = 3'd3,
        MODE_LINEAR  = 3'd4
    } t_act_mode;

    typedef enum logic {
        CFG_MODE = 1'b0,
        CFG_BIAS = 1'b1
    } t_cfg_index;

    typedef logic [8:0] t_sig_lut [SIGMOID_ENTRIES];

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv64(longint unsigned num,
                                               longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sigmoid(p/256) in Q1.8, exp(-|p|/256) built in Q0.32
    function automatic logic [8:0] sig_q8(int p);
        longint unsigned a;
        longint unsigned frac;
        longint unsigned whole;
        longint unsigned t;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned step_div;
        a     = (p < 0) ? longint'(-p) : longint'(p);
        frac  = a & 64'd255;
        whole = a >> 8;
        t     = ONE_Q32;
        pos   = ONE_Q32;
        neg   = 64'd0;
        for (int n = 1; n <= 24; n++) begin
            step_div = 64'd256 * longint'(n);
            t = udiv64(t * frac, step_div);
            if ((n % 2) == 1) begin
                neg = neg + t;
            end else begin
                pos = pos + t;
            end
        end
        e = pos - neg;
        for (longint unsigned k = 0; k < whole; k++) begin
            e = (e * EXP_M1_Q32 + HALF_Q32) >> 32;
        end
        num = (p < 0) ? e : ONE_Q32;
        den = ONE_Q32 + e;
        return 9'(udiv64(num * 64'd256 + (den >> 1), den));
    endfunction

    function automatic t_sig_lut build_sigmoid_lut();
        t_sig_lut lut;
        for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
            lut[i] = sig_q8(int'((longint'(i) * 4096) / SIGMOID_ENTRIES) - 2048);
        end
        return lut;
    endfunction

    localparam t_sig_lut SIGMOID_LUT = build_sigmoid_lut();

endpackage

/* sv/nau_in_if.sv */
// ============================================================================
// nau_in_if
// Input channel: opcode and sample value with valid/ready handshake.
// ============================================================================
interface nau_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic signed [15:0] sample_value;

    modport source (output valid, output opcode, output sample_value, input ready);
    modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

/* sv/nau_out_if.sv */
// ============================================================================
// nau_out_if
// Result channel: activation value and cache flag with valid/ready handshake.
// ============================================================================
interface nau_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] activation_out;
    logic               from_cache;

    modport source (output valid, output activation_out, output from_cache, input ready);
    modport sink   (input valid, input activation_out, input from_cache, output ready);
endinterface

/* sv/neuron_activation_unit_core.sv */
// ============================================================================
// neuron_activation_unit_core
// Single network node: saturating Q16.8 accumulator, activation with bias,
// latched result returned on later reads until cleared.
// ============================================================================
//  channel   dir  payload                          transaction
//  i_in      in   opcode, sample_value             valid & ready
//  o_out     out  activation_out, from_cache       valid & ready (reads only)
//  i_cfg_*   in   index, data                      wr_en
//
//  One transaction per cycle sustained; a read result passes through the
//  input register, then the result register.
//  Sum and latch state update in the single process stage.
//  Synchronous active-low reset clears valid flags, sum, latch and configuration; no clearing pass.
//  A stalled result holds the stage only for reads; accumulate and clear
//  keep flowing.
// ============================================================================
module neuron_activation_unit_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nau_in_if.sink            i_in,
    nau_out_if.source         o_out,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_index,
    input  logic [nau_pkg::CFG_W-1:0] i_cfg_data
);
    import nau_pkg::*;

    logic                         r_in_valid;
    logic [1:0]                   r_in_op;
    logic signed [DATA_W-1:0]     r_in_sample;

    logic signed [SUM_WIDTH-1:0]  r_sum;
    logic signed [SUM_WIDTH-1:0]  n_sum;
    logic signed [DATA_W-1:0]     r_latched;
    logic                         r_lat_valid;

    t_act_mode                    r_mode;
    logic signed [DATA_W-1:0]     r_bias;

    logic                         r_out_valid;
    logic signed [DATA_W-1:0]     r_out_act;
    logic                         r_out_cache;

    logic                         w_out_free;
    logic                         w_adv;
    logic                         w_is_read;

    logic signed [SUM_WIDTH:0]    w_acc_wide;
    logic signed [13:0]           w_steep_in;
    logic signed [STEEP_W-1:0]    w_steep_prod;
    logic signed [16:0]           w_steep_val;
    logic signed [11:0]           w_sig_x;
    logic [11:0]                  w_sig_u;
    logic [SIG_PROD_W-1:0]        w_sig_prod;
    logic [SIG_IDX_W-1:0]         w_sig_idx;
    logic [8:0]                   w_sig_val;
    logic signed [SUM_WIDTH-1:0]  w_act;
    logic signed [SUM_WIDTH:0]    w_biased;
    logic signed [DATA_W-1:0]     w_result;

    assign w_is_read  = (t_opcode'(r_in_op) == OP_READ);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && (!w_is_read || w_out_free);
    assign i_in.ready = !r_in_valid || w_adv;

    assign o_out.valid          = r_out_valid;
    assign o_out.activation_out = r_out_act;
    assign o_out.from_cache     = r_out_cache;

    // saturating accumulate
    always_comb begin
        w_acc_wide = $signed({r_sum[SUM_WIDTH-1], r_sum})
                   + $signed((SUM_WIDTH + 1)'(r_in_sample));
        if (w_acc_wide[SUM_WIDTH] != w_acc_wide[SUM_WIDTH-1]) begin
            n_sum = w_acc_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            n_sum = w_acc_wide[SUM_WIDTH-1:0];
        end
    end

    // steep sigmoid prescale by 4.9
    always_comb begin
        if (r_sum > 4096) begin
            w_steep_in = 14'sd4096;
        end else if (r_sum < -4096) begin
            w_steep_in = -14'sd4096;
        end else begin
            w_steep_in = r_sum[13:0];
        end
        w_steep_prod = $signed(STEEP_W'(w_steep_in)) * $signed(STEEP_W'(1254));
        w_steep_val  = w_steep_prod[STEEP_W-1:8];
    end

    // sigmoid table lookup
    always_comb begin
        if (r_mode == MODE_STEEP) begin
            if (w_steep_val > 2047) begin
                w_sig_x = 12'sd2047;
            end else if (w_steep_val < -2048) begin
                w_sig_x = -12'sd2048;
            end else begin
                w_sig_x = w_steep_val[11:0];
            end
        end else begin
            if (r_sum > 2047) begin
                w_sig_x = 12'sd2047;
            end else if (r_sum < -2048) begin
                w_sig_x = -12'sd2048;
            end else begin
                w_sig_x = r_sum[11:0];
            end
        end
        w_sig_u    = {~w_sig_x[11], w_sig_x[10:0]};
        w_sig_prod = SIG_PROD_W'(w_sig_u) * SIG_PROD_W'(SIGMOID_ENTRIES);
        w_sig_idx  = w_sig_prod[12 +: SIG_IDX_W];
        w_sig_val  = SIGMOID_LUT[w_sig_idx];
    end

    // activation select, bias and saturation
    always_comb begin
        unique case (r_mode)
            MODE_RELU: begin
                w_act = r_sum[SUM_WIDTH-1] ? '0 : r_sum;
            end
            MODE_STEP: begin
                w_act = (r_sum >= 256) ? SUM_WIDTH'(256) : '0;
            end
            MODE_LINEAR: begin
                w_act = r_sum;
            end
            default: begin
                w_act = $signed(SUM_WIDTH'(w_sig_val));
            end
        endcase
        w_biased = $signed({w_act[SUM_WIDTH-1], w_act})
                 + $signed((SUM_WIDTH + 1)'(r_bias));
        if (w_biased > 32767) begin
            w_result = 16'sh7FFF;
        end else if (w_biased < -32768) begin
            w_result = -16'sh8000;
        end else begin
            w_result = w_biased[DATA_W-1:0];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op     <= i_in.opcode;
            r_in_sample <= i_in.sample_value;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SIGMOID;
            r_bias <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MODE: r_mode <= t_act_mode'(i_cfg_data[2:0]);
                CFG_BIAS: r_bias <= i_cfg_data[DATA_W-1:0];
            endcase
        end
    end

    // node state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_latched   <= '0;
            r_lat_valid <= 1'b0;
        end else if (w_adv) begin
            unique case (t_opcode'(r_in_op))
                OP_ACCUM: begin
                    r_sum <= n_sum;
                end
                OP_CLEAR: begin
                    r_sum       <= '0;
                    r_latched   <= '0;
                    r_lat_valid <= 1'b0;
                end
                OP_READ: begin
                    if (!r_lat_valid) begin
                        r_latched   <= w_result;
                        r_lat_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_is_read) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_is_read) begin
            r_out_act   <= r_lat_valid ? r_latched : w_result;
            r_out_cache <= r_lat_valid;
        end
    end

`ifndef SYNTHESIS
    a_clear_drops_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && t_opcode'(r_in_op) == OP_CLEAR) |=> !r_lat_valid)
        else $error("latched output survived a clear");

    a_read_sets_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_read) |=> (r_out_valid && r_lat_valid))
        else $error("read did not produce a latched result");

    a_fresh_not_cached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_read && !r_lat_valid) |=> !o_out.from_cache)
        else $error("first read flagged as cached");
`endif

endmodule
